/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define PCA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables the check
`define PCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pca_pkg.sv */
`timescale 1ns / 1ps
package pca_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int NUM_CHAN        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WB_RED     = 3'd0,
    CFG_WB_GREEN   = 3'd1,
    CFG_WB_BLUE    = 3'd2,
    CFG_EXPOSURE   = 3'd3,
    CFG_CONTRAST   = 3'd4,
    CFG_BRIGHTNESS = 3'd5,
    CFG_SHADOW_THR = 3'd6,
    CFG_SHADOW_EXP = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] wb_gain_red;
    logic        [15:0] wb_gain_green;
    logic        [15:0] wb_gain_blue;
    logic        [23:0] exposure_gain;
    logic signed [15:0] contrast_gain;
    logic signed [17:0] brightness_offset;
    logic        [15:0] shadow_threshold;
    logic        [23:0] shadow_exposure_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wb_gain_red:          16'd4096,
    wb_gain_green:        16'd4096,
    wb_gain_blue:         16'd4096,
    exposure_gain:        24'd65536,
    contrast_gain:        16'sd4096,
    brightness_offset:    18'sd0,
    shadow_threshold:     16'd0,
    shadow_exposure_gain: 24'd65536
  };

endpackage

/* sv/pca_if.sv */
`timescale 1ns / 1ps
interface pca_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] in_red;
  logic [SAMPLE_BITS-1:0] in_green;
  logic [SAMPLE_BITS-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

interface pca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       shadow_taken;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output shadow_taken, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input shadow_taken, output ready);
endinterface

/* sv/pca_chan.sv */
`timescale 1ns / 1ps
module pca_chan #(
  parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  logic [15:0]                       wb_gain,
  input  pca_pkg::cfg_t                     cfg,
  output logic signed [SAMPLE_BITS+56:0]    t_main,
  output logic signed [SAMPLE_BITS+56:0]    t_shadow
);
  import pca_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int K  = S + 40;   // result scale 2^K
  localparam int TW = S + 57;   // signed width of adjusted value
  localparam int XW = S + 40;   // exposed value, scale 2^(S+28)

  localparam logic signed [XW:0]   HALF_X = (XW+1)'(1) << (S + 27);
  localparam logic signed [TW-1:0] HALF_K = TW'(1) << (K - 1);

  // stage 1: sample
  logic [S-1:0]           s_r;
  // stage 2: white balance product and shadow exposure product
  logic [S+15:0]          p_r;
  logic [S+23:0]          xs_r;
  // stage 3: exposed values
  logic [XW-1:0]          xm_r, xm_nxt;
  logic [XW-1:0]          xsh_r, xsh_nxt;
  // stage 4: contrast products
  logic signed [XW:0]     dm, ds;
  logic signed [TW-1:0]   dm_r, dm_nxt, ds_r, ds_nxt;
  // stage 5: offset applied
  logic signed [TW-1:0]   b_ext;
  logic signed [TW-1:0]   tm_r, tm_nxt, ts_r, ts_nxt;

  assign xm_nxt  = p_r * cfg.exposure_gain;
  assign xsh_nxt = XW'({xs_r, 12'h000});

  assign dm = $signed({1'b0, xm_r}) - HALF_X;
  assign ds = $signed({1'b0, xsh_r}) - HALF_X;
  assign dm_nxt = TW'(dm) * TW'(cfg.contrast_gain);
  assign ds_nxt = TW'(ds) * TW'(cfg.contrast_gain);

  assign b_ext  = TW'(cfg.brightness_offset) <<< (K - 16);
  assign tm_nxt = dm_r + HALF_K + b_ext;
  assign ts_nxt = ds_r + HALF_K + b_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= sample;
      p_r   <= s_r * wb_gain;
      xs_r  <= s_r * cfg.shadow_exposure_gain;
      xm_r  <= xm_nxt;
      xsh_r <= xsh_nxt;
      dm_r  <= dm_nxt;
      ds_r  <= ds_nxt;
      tm_r  <= tm_nxt;
      ts_r  <= ts_nxt;
    end
  end

  assign t_main   = tm_r;
  assign t_shadow = ts_r;

endmodule

/* sv/pca_decide.sv */
`timescale 1ns / 1ps
module pca_decide #(
  parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_BITS+56:0] t_main   [pca_pkg::NUM_CHAN],
  input  logic signed [SAMPLE_BITS+56:0] t_shadow [pca_pkg::NUM_CHAN],
  input  logic [15:0]                    shadow_threshold,
  output logic [7:0]                     pix      [pca_pkg::NUM_CHAN],
  output logic                           shadow_taken
);
  import pca_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int K  = S + 40;
  localparam int TW = S + 57;
  localparam int SW = TW + 2;

  logic signed [SW-1:0] sum;
  logic [17:0]          lim3;
  logic [SW-1:0]        lim;
  logic                 shadow_nxt, shadow_r;
  logic [7:0]           bm_r [NUM_CHAN];
  logic [7:0]           bs_r [NUM_CHAN];

  // floor(255 * t / 2^K) clamped to a byte
  function automatic logic [7:0] to_byte(input logic signed [TW-1:0] t);
    logic [K+7:0] y;
    y = {t[K-1:0], 8'h00} - (K+8)'(t[K-1:0]);
    if (t[TW-1]) begin
      return 8'h00;
    end else if (|t[TW-2:K]) begin
      return 8'hff;
    end else begin
      return y[K+7:K];
    end
  endfunction

  assign sum = SW'(t_main[0]) + SW'(t_main[1]) + SW'(t_main[2]);
  assign lim3 = 18'(shadow_threshold) * 18'd3;
  assign lim  = SW'(lim3) << (K - 16);
  assign shadow_nxt = (shadow_threshold != 16'd0) && ($signed(lim) >= sum);

  always_ff @(posedge clk) begin
    if (en) begin
      shadow_r <= shadow_nxt;
      for (int i = 0; i < NUM_CHAN; i++) begin
        bm_r[i] <= to_byte(t_main[i]);
        bs_r[i] <= to_byte(t_shadow[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      pix[i] = shadow_r ? bs_r[i] : bm_r[i];
    end
  end

  assign shadow_taken = shadow_r;

endmodule

/* sv/pixel_color_adjust_top.sv */
// channel   dir  handshake      payload
// in_ch     in   valid/ready    in_red, in_green, in_blue (SAMPLE_BITS each)
// out_ch    out  valid/ready    out_red, out_green, out_blue, shadow_taken
// cfg_*     in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// six register stages, one pixel per clock while the output is not stalled
// stage depth is set by the contrast multiply (sample width + 41 by 16 bits)
// synchronous active-low reset clears valid bits and loads register defaults
// a stalled output holds the whole pipeline; nothing is dropped or repeated
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pixel_color_adjust_top #(
  parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pca_in_if.sink                           in_ch,
  pca_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pca_pkg::*;

  localparam int TW  = SAMPLE_BITS + 57;
  localparam int NST = 6;

  cfg_t                 cfg_r, cfg_nxt;
  logic [NST-1:0]       vld_r, vld_nxt;
  logic                 en;
  logic                 in_fire;
  logic [SAMPLE_BITS-1:0] samp [NUM_CHAN];
  logic [15:0]          wb   [NUM_CHAN];
  logic signed [TW-1:0] tm   [NUM_CHAN];
  logic signed [TW-1:0] ts   [NUM_CHAN];
  logic [7:0]           pix  [NUM_CHAN];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WB_RED:     cfg_nxt.wb_gain_red          = cfg_wdata[15:0];
        CFG_WB_GREEN:   cfg_nxt.wb_gain_green        = cfg_wdata[15:0];
        CFG_WB_BLUE:    cfg_nxt.wb_gain_blue         = cfg_wdata[15:0];
        CFG_EXPOSURE:   cfg_nxt.exposure_gain        = cfg_wdata[23:0];
        CFG_CONTRAST:   cfg_nxt.contrast_gain        = $signed(cfg_wdata[15:0]);
        CFG_BRIGHTNESS: cfg_nxt.brightness_offset    = $signed(cfg_wdata[17:0]);
        CFG_SHADOW_THR: cfg_nxt.shadow_threshold     = cfg_wdata[15:0];
        CFG_SHADOW_EXP: cfg_nxt.shadow_exposure_gain = cfg_wdata[23:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // whole pipeline advances unless a result is waiting for transfer
  assign en      = !vld_r[NST-1] || out_ch.ready;
  assign in_fire = in_ch.valid && en;
  assign vld_nxt = en ? {vld_r[NST-2:0], in_ch.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      vld_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign samp[0] = in_ch.in_red;
  assign samp[1] = in_ch.in_green;
  assign samp[2] = in_ch.in_blue;
  assign wb[0]   = cfg_r.wb_gain_red;
  assign wb[1]   = cfg_r.wb_gain_green;
  assign wb[2]   = cfg_r.wb_gain_blue;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    pca_chan #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chan (
      .clk      (clk),
      .en       (en),
      .sample   (samp[c]),
      .wb_gain  (wb[c]),
      .cfg      (cfg_r),
      .t_main   (tm[c]),
      .t_shadow (ts[c])
    );
  end

  pca_decide #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decide (
    .clk              (clk),
    .en               (en),
    .t_main           (tm),
    .t_shadow         (ts),
    .shadow_threshold (cfg_r.shadow_threshold),
    .pix              (pix),
    .shadow_taken     (out_ch.shadow_taken)
  );

  assign in_ch.ready      = en;
  assign out_ch.valid     = vld_r[NST-1];
  assign out_ch.out_red   = pix[0];
  assign out_ch.out_green = pix[1];
  assign out_ch.out_blue  = pix[2];

  `PCA_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    $stable(vld_r), "pipeline valid bits moved during output stall")
  `PCA_ASSERT_NEXT(a_empty_quiet, clk, rst_n, !(|vld_r) && !in_fire,
    !out_ch.valid, "result appeared from an empty pipeline")
  `PCA_ASSERT_SAME(a_out_source, clk, rst_n, $rose(out_ch.valid),
    $past(vld_r[NST-2]), "result valid rose without a pixel in the last stage")

endmodule
